// File: design/flc_pkg.sv
package flc_pkg;

  localparam int MAX_TAPS     = 32;
  localparam int SAMPLE_WIDTH = 16;
  localparam int ACC_WIDTH    = 40;

  localparam int IDX_W  = $clog2(MAX_TAPS);
  localparam int TAP_W  = $clog2(MAX_TAPS + 1);
  localparam int PROD_W = 2 * SAMPLE_WIDTH;

  // product register plus one sum stage per cell
  localparam int LAT   = MAX_TAPS + 1;
  localparam int CNT_W = $clog2(LAT + 1);

  localparam int TAPCNT_W   = 6;
  localparam int OLEN_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = ((IDX_W + SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ACC_WIDTH + 7) / 8) * 8;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [ACC_WIDTH-1:0]    acc_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic [IDX_W-1:0]               idx_t;
  typedef logic [TAP_W-1:0]               taps_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LENGTH = CFG_IDX_W'(1);

  typedef struct packed {
    logic shift;
    logic clear;
    logic coef_we;
    idx_t coef_idx;
  } cell_ctl_t;

  function automatic taps_t taps_in_use(logic [TAPCNT_W-1:0] tc);
    taps_t res;
    if (tc == '0) begin
      res = taps_t'(1);
    end else if (int'(tc) > MAX_TAPS) begin
      res = taps_t'(MAX_TAPS);
    end else begin
      res = taps_t'(tc);
    end
    return res;
  endfunction

endpackage

// File: design/fir_linear_convolution.sv
// FIR filter by direct linear convolution over a chain of tap cells.
// Input channel (in_*): in_tuser = 0 loads in_tdata's value into coefficient
// coef_index; in_tuser = 1 pushes value as a sample. in_tlast on a sample
// ends the sequence: the zero tail of taps-1 outputs follows, then the delay
// line clears and the per-sequence output count restarts.
// Output channel (out_*): one 40-bit Q10.30 sum per output, out_tlast on the
// last output of a sequence (flush end or output_length reached).
// Config channel (cfg_*): index 0 = tap_count, 1 = output_length; always
// ready, write only while no item is in flight.
// Steps: a load is done on acceptance. Each output runs through one product
// stage plus one sum stage per cell, the line held still meanwhile; a last
// sample runs this once for itself and once for each output of its tail.
// One item is worked on at a time; the next item is taken while the result
// register still waits. A stalled receiver holds the result and stops the
// chain only when the next output is ready to be written.
// Reset (rst_n low, synchronous): coefficients and delay line zero,
// tap_count = 32, output_length = 65535, no output pending.
module fir_linear_convolution (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: coef_index, value, zero pad (low bit up); in_tuser: opcode
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [flc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  // out_tdata: output_value
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [flc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [flc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [flc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import flc_pkg::*;

  cell_ctl_t cell_ctl;
  sample_t   head_sample;
  sample_t   coef_wdata;
  taps_t     taps;
  sample_t   samp_link [MAX_TAPS+1];
  acc_t      sum_link  [MAX_TAPS+1];

  flc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cell_ctl    (cell_ctl),
    .head_sample (head_sample),
    .coef_wdata  (coef_wdata),
    .taps        (taps),
    .chain_sum   (sum_link[MAX_TAPS])
  );

  // samples walk down the chain on a shift, partial sums every cycle
  assign samp_link[0] = head_sample;
  assign sum_link[0]  = '0;

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_tap
    flc_tap_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (idx_t'(i)),
      .active     (TAP_W'(i) < taps),
      .ctl        (cell_ctl),
      .coef_wdata (coef_wdata),
      .sample_in  (samp_link[i]),
      .sample_out (samp_link[i+1]),
      .sum_in     (sum_link[i]),
      .sum_out    (sum_link[i+1])
    );
  end

`ifndef NO_ASSERTIONS
  // reset leaves the block idle with nothing pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

  // a coefficient load finishes in its own cycle
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_LOAD |=> in_tready)
    else $error("load item held the input channel");

  // a sample keeps the input closed while its sum runs down the chain
  a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_PUSH |=> !in_tready ##1 !in_tready)
    else $error("sample item released the input too early");
`endif

endmodule

// File: design/flc_tap_cell.sv
module flc_tap_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  flc_pkg::idx_t      cell_idx,
  input  logic               active,
  input  flc_pkg::cell_ctl_t ctl,
  input  flc_pkg::sample_t   coef_wdata,
  input  flc_pkg::sample_t   sample_in,
  output flc_pkg::sample_t   sample_out,
  input  flc_pkg::acc_t      sum_in,
  output flc_pkg::acc_t      sum_out
);
  import flc_pkg::*;

  sample_t coef_r, coef_nxt;
  sample_t dl_r, dl_nxt;
  acc_t    prod_r;
  acc_t    sum_r;
  prod_t   prod;

  always_comb begin
    coef_nxt = coef_r;
    if (ctl.coef_we && ctl.coef_idx == cell_idx) begin
      coef_nxt = coef_wdata;
    end
    dl_nxt = dl_r;
    if (ctl.clear) begin
      dl_nxt = '0;
    end else if (ctl.shift) begin
      dl_nxt = sample_in;
    end
    prod = prod_t'(coef_r) * prod_t'(dl_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      dl_r   <= '0;
    end else begin
      coef_r <= coef_nxt;
      dl_r   <= dl_nxt;
    end
  end

  // product and running sum free-run; the line holds still while a sum settles
  always_ff @(posedge clk) begin
    prod_r <= active ? acc_t'(prod) : '0;
    sum_r  <= sum_in + prod_r;
  end

  assign sample_out = dl_r;
  assign sum_out    = sum_r;

endmodule

// File: design/flc_ctrl.sv
module flc_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [flc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [flc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [flc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [flc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output flc_pkg::cell_ctl_t              cell_ctl,
  output flc_pkg::sample_t                head_sample,
  output flc_pkg::sample_t                coef_wdata,
  output flc_pkg::taps_t                  taps,
  input  flc_pkg::acc_t                   chain_sum
);
  import flc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CALC = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  taps_t                 rem_r, rem_nxt;
  logic                  last_r, last_nxt;
  logic [OLEN_W-1:0]     emitted_r, emitted_nxt;
  logic [TAPCNT_W-1:0]   tapcnt_r, tapcnt_nxt;
  logic [OLEN_W-1:0]     olen_r, olen_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic                  olast_r, olast_nxt;
  acc_t                  odata_r, odata_nxt;

  logic                  accept;
  logic                  done;
  logic                  suppress;
  logic                  emit_ok;
  logic [OLEN_W-1:0]     emitted_inc;
  idx_t                  in_idx;
  sample_t               in_value;

  assign in_idx   = in_tdata[IDX_W-1:0];
  assign in_value = sample_t'(in_tdata[IDX_W +: SAMPLE_WIDTH]);
  assign taps     = taps_in_use(tapcnt_r);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    last_nxt    = last_r;
    emitted_nxt = emitted_r;
    tapcnt_nxt  = tapcnt_r;
    olen_nxt    = olen_r;
    odata_nxt   = odata_r;
    olast_nxt   = olast_r;
    ovalid_nxt  = ovalid_r && !out_tready;

    cell_ctl    = '0;
    head_sample = '0;
    coef_wdata  = in_value;
    cell_ctl.coef_idx = in_idx;

    in_tready   = (state_r == S_IDLE);
    cfg_ready   = 1'b1;
    accept      = in_tvalid && in_tready;
    done        = (cnt_r == CNT_W'(LAT));
    suppress    = (emitted_r >= olen_r);
    emit_ok     = done && (suppress || !ovalid_r || out_tready);
    emitted_inc = emitted_r + OLEN_W'(1);

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_TAP_COUNT:     tapcnt_nxt = cfg_data[TAPCNT_W-1:0];
        REG_OUTPUT_LENGTH: olen_nxt   = cfg_data[OLEN_W-1:0];
        default:           ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_tuser == OP_LOAD) begin
            cell_ctl.coef_we = 1'b1;
          end else begin
            cell_ctl.shift = 1'b1;
            head_sample    = in_value;
            rem_nxt        = in_tlast ? taps - taps_t'(1) : '0;
            last_nxt       = in_tlast;
            cnt_nxt        = '0;
            state_nxt      = S_CALC;
          end
        end
      end
      S_CALC: begin
        if (!done) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else if (emit_ok) begin
          if (!suppress) begin
            odata_nxt   = chain_sum;
            olast_nxt   = (emitted_inc == olen_r) || (last_r && rem_r == '0);
            ovalid_nxt  = 1'b1;
            emitted_nxt = emitted_inc;
          end
          if (rem_r != '0) begin
            // tail: push a zero and run the sum again
            cell_ctl.shift = 1'b1;
            rem_nxt        = rem_r - taps_t'(1);
            cnt_nxt        = '0;
          end else begin
            if (last_r) begin
              cell_ctl.clear = 1'b1;
              emitted_nxt    = '0;
            end
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      rem_r     <= '0;
      last_r    <= 1'b0;
      emitted_r <= '0;
      tapcnt_r  <= TAPCNT_W'(32);
      olen_r    <= OLEN_W'(65535);
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rem_r     <= rem_nxt;
      last_r    <= last_nxt;
      emitted_r <= emitted_nxt;
      tapcnt_r  <= tapcnt_nxt;
      olen_r    <= olen_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = OUT_TDATA_W'($unsigned(odata_r));

endmodule

// File: bench/fir_linear_convolution_tb.sv
module fir_linear_convolution_tb;
  import flc_pkg::*;

  localparam int HALF_PERIOD = 4;
  // worst-case in-flight work after the last expected output: a full flush
  // at MAX_TAPS taps, plus some margin
  localparam int DRAIN_WAIT = MAX_TAPS * (MAX_TAPS + 2) + 16;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int MAX_REPORTS = 10;

  // one pending input item; hold makes the driver wait for an empty scoreboard
  typedef struct {
    logic    op;
    idx_t    idx;
    sample_t val;
    logic    last;
    logic    hold;
  } fir_item_t;

  typedef struct {
    acc_t value;
    logic last;
  } conv_out_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // coef_index, value, zero pad (low bit up)
  logic                   in_tuser   = 1'b0; // opcode
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // output_value
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  fir_item_t   item_q[$];
  conv_out_t   conv_expected[$];
  int unsigned items_queued = 0;
  int unsigned items_taken  = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned n_mismatch   = 0;

  // filter shadow: coefficients, delay line, per-sequence output count, config
  sample_t             coef_mem[MAX_TAPS];
  sample_t             line_mem[MAX_TAPS];
  int unsigned         outs_in_seq;
  logic [TAPCNT_W-1:0] tap_count_reg;
  logic [OLEN_W-1:0]   out_len_reg;

  always #HALF_PERIOD clk = ~clk;

  fir_linear_convolution uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Convolution predictor
  // ---------------------------------------------------------------------------

  // zero taps behave as one, anything past the store size as the full store
  function automatic int unsigned eff_taps();
    if (tap_count_reg == '0) return 1;
    if (tap_count_reg > MAX_TAPS) return MAX_TAPS;
    return 32'(tap_count_reg);
  endfunction

  // Q2.30 products summed into the 40-bit accumulator, wrapping
  function automatic acc_t fir_sum(int unsigned taps);
    acc_t  acc;
    prod_t p;
    acc = '0;
    for (int i = 0; i < taps; i++) begin
      p   = prod_t'(coef_mem[i]) * prod_t'(line_mem[i]);
      acc = acc + acc_t'(p);
    end
    return acc;
  endfunction

  function automatic void shift_line(sample_t s);
    for (int i = MAX_TAPS - 1; i > 0; i--) line_mem[i] = line_mem[i-1];
    line_mem[0] = s;
  endfunction

  // outputs past output_length are dropped; the one that reaches it ends
  // the sequence as far as the receiver can tell
  function automatic void queue_output(acc_t sum, logic flush_end);
    conv_out_t o;
    if (outs_in_seq >= out_len_reg) return;
    outs_in_seq++;
    o.value = sum;
    o.last  = (outs_in_seq == out_len_reg) || flush_end;
    conv_expected.push_back(o);
  endfunction

  function automatic void predict_item(logic op, idx_t idx, sample_t v, logic last);
    int unsigned taps;
    taps = eff_taps();
    if (op == OP_LOAD) begin
      coef_mem[idx] = v;  // last mark on a load means nothing
      return;
    end
    shift_line(v);
    queue_output(fir_sum(taps), last && taps == 1);
    if (last) begin
      // zero tail: taps-1 more outputs, then a fresh sequence
      for (int t = 1; t < taps; t++) begin
        shift_line('0);
        queue_output(fir_sum(taps), t == taps - 1);
      end
      foreach (line_mem[i]) line_mem[i] = '0;
      outs_in_seq = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: drives the items of item_q, predicts each item as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    fir_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_item(in_tuser, in_tdata[IDX_W-1:0], in_tdata[IDX_W +: SAMPLE_WIDTH],
                     in_tlast);
        items_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (item_q.size() != 0 && !(item_q[0].hold && conv_expected.size() != 0) &&
            $urandom_range(99) >= snd_idle_pct) begin
          nxt = item_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.op;
          in_tlast  <= nxt.last;
          in_tdata  <= IN_TDATA_W'({nxt.val, nxt.idx});
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: in-order compare against the predicted outputs
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check
    conv_out_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (conv_expected.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display("unexpected output: value=%0d last=%b",
                     $signed(out_tdata[ACC_WIDTH-1:0]), out_tlast);
        end else begin
          want = conv_expected.pop_front();
          if (out_tdata[ACC_WIDTH-1:0] !== want.value || out_tlast !== want.last) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
              $display("output mismatch: expected value=%0d last=%b, got value=%0d last=%b",
                       want.value, want.last, $signed(out_tdata[ACC_WIDTH-1:0]), out_tlast);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_item(logic op, int unsigned idx, sample_t v, logic last,
                                   logic hold);
    fir_item_t it;
    it.op   = op;
    it.idx  = idx_t'(idx);
    it.val  = v;
    it.last = last;
    it.hold = hold;
    item_q.push_back(it);
    items_queued++;
  endfunction

  // full-scale values and zero show up often
  function automatic sample_t rand_q15();
    case ($urandom_range(9))
      0:       return sample_t'(-32768);
      1:       return sample_t'(32767);
      2:       return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // at times one to four coefficient loads, then samples, mostly ending in a
  // last mark; sometimes a stray load mid-sequence or a sequence left open
  function automatic void add_sequence(logic with_hold);
    int unsigned n_loads;
    int unsigned n_samples;
    logic        ends;
    n_loads   = ($urandom_range(99) < 35) ? $urandom_range(1, 4) : 0;
    n_samples = $urandom_range(1, 8);
    ends      = ($urandom_range(99) < 90);
    for (int i = 0; i < n_loads; i++)
      add_item(OP_LOAD, $urandom_range(MAX_TAPS - 1), rand_q15(), 1'($urandom_range(1)),
               1'b0);
    for (int i = 0; i < n_samples; i++) begin
      if ($urandom_range(99) < 5)
        add_item(OP_LOAD, $urandom_range(MAX_TAPS - 1), rand_q15(), 1'($urandom_range(1)),
                 1'b0);
      add_item(OP_PUSH, $urandom_range(MAX_TAPS - 1), rand_q15(),
               ends && i == n_samples - 1, with_hold && i == 0);
    end
  endfunction

  // both registers back to back; upper tap_count bits are don't-care
  task automatic set_config(int unsigned taps, int unsigned olen);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[TAPCNT_W-1:0] = TAPCNT_W'(taps);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TAP_COUNT;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    tap_count_reg = d[TAPCNT_W-1:0];
    cfg_index <= REG_OUTPUT_LENGTH;
    cfg_data  <= CFG_DATA_W'(olen);
    do @(posedge clk); while (!cfg_ready);
    out_len_reg = OLEN_W'(olen);
    cfg_valid <= 1'b0;
  endtask

  // everything accepted, every output seen, and room for suppressed work
  task automatic wait_idle();
    while (items_taken != items_queued) @(posedge clk);
    while (conv_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned taps, int unsigned olen);
    int unsigned start;
    set_config(taps, olen);
    start = items_queued;
    add_sequence(1'b1);
    while (items_queued - start < ITEMS_PER_PHASE) add_sequence(1'b0);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    tap_count_reg = TAPCNT_W'(MAX_TAPS);
    out_len_reg   = '1;
    outs_in_seq   = 0;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    foreach (line_mem[i]) line_mem[i] = '0;
    snd_idle_pct = 25;
    rcv_idle_pct = 50;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset config (32 taps, no length limit): extreme coefficients and
    // samples, then a full 31-output tail
    add_item(OP_LOAD, 0, sample_t'(-32768), 1'b0, 1'b0);
    add_item(OP_LOAD, MAX_TAPS - 1, sample_t'(32767), 1'b1, 1'b0);  // last mark ignored
    add_item(OP_LOAD, 1, sample_t'(32767), 1'b0, 1'b0);
    add_item(OP_PUSH, 0, sample_t'(-32768), 1'b0, 1'b0);
    add_item(OP_PUSH, MAX_TAPS - 1, sample_t'(32767), 1'b0, 1'b0);
    add_item(OP_PUSH, 0, '0, 1'b0, 1'b0);
    add_item(OP_PUSH, 0, sample_t'(-1), 1'b1, 1'b0);
    wait_idle();

    // zero taps act as one; length 3 cuts the sequence short, the rest is
    // dropped until the last mark restarts the count
    set_config(0, 3);
    add_item(OP_PUSH, 0, sample_t'(32767), 1'b0, 1'b1);
    add_item(OP_PUSH, 0, sample_t'(-32768), 1'b0, 1'b0);
    add_item(OP_PUSH, 0, sample_t'(1), 1'b0, 1'b0);
    add_item(OP_PUSH, 0, sample_t'(5), 1'b0, 1'b0);
    add_item(OP_PUSH, 0, sample_t'(-7), 1'b1, 1'b0);
    add_item(OP_PUSH, 0, sample_t'(100), 1'b0, 1'b0);
    add_item(OP_PUSH, 0, sample_t'(12), 1'b1, 1'b0);
    wait_idle();

    // tap count past the store clamps; zero length drops every output
    set_config((1 << TAPCNT_W) - 1, 0);
    add_item(OP_PUSH, 3, sample_t'(1), 1'b0, 1'b0);
    add_item(OP_LOAD, 2, sample_t'(-2), 1'b0, 1'b0);
    add_item(OP_PUSH, 7, sample_t'(2), 1'b1, 1'b0);
    wait_idle();

    run_phase(1, (1 << OLEN_W) - 1);
    run_phase(MAX_TAPS, (1 << OLEN_W) - 1);

    snd_idle_pct = 50;
    rcv_idle_pct = 25;
    run_phase($urandom_range(2, 8), $urandom_range(1, 6));
    run_phase($urandom_range(1, MAX_TAPS), 1);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_phase(MAX_TAPS + 1 + $urandom_range(30), $urandom_range(2, 40));
    run_phase($urandom_range(3, 16), (1 << OLEN_W) - 1);

    if (n_mismatch == 0 && conv_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #16_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
design/flc_pkg.sv
design/flc_tap_cell.sv
design/flc_ctrl.sv
design/fir_linear_convolution.sv
bench/fir_linear_convolution_tb.sv
